@@ hw/rtl/dpsqrt_pkg.sv @@
// Shared types and constants for the binary64 square root core.
package dpsqrt_pkg;

    localparam int unsigned FracW = 52;
    localparam int unsigned SigW = 53;
    localparam int unsigned RemW = 56;
    localparam int unsigned IterN = 53;
    localparam logic [10:0] ExpBias = 11'd1023;
    localparam logic [63:0] DefaultNan = 64'h7FF8_0000_0000_0000;
    localparam logic [63:0] QuietBit = 64'h0008_0000_0000_0000;

    // Rounding mode codes.
    localparam logic [1:0] RmNearest = 2'd0;
    localparam logic [1:0] RmZero = 2'd1;
    localparam logic [1:0] RmUp = 2'd2;

    // Handshake between controller and root unit.
    typedef struct packed {
        logic start;
        logic done;
    } root_ctl_t;

endpackage

@@ hw/rtl/double_precision_square_root_core.sv @@
// Sequence for a finite positive operand: input transfer, normalize step, root
// iterations, done strobe, round step, result valid; a special operand goes from
// the normalize step straight to result valid. Operands are taken one at a time:
// the next input transfer waits until the last result has been taken.
// Reset clears control state and sets the rounding mode to nearest-even.
// Top level of the binary64 square root core.
module double_precision_square_root_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // operand_bits[63:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // result_bits[63:0]
    output logic [1:0]  m_axis_tuser    // inexact, invalid
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_NORM = 5'b00010,
        ST_ROOT = 5'b00100,
        ST_RND  = 5'b01000,
        ST_OUT  = 5'b10000
    } state_t;

    state_t state_reg;
    logic [1:0] mode_reg;
    logic [63:0] x_reg;
    logic [dpsqrt_pkg::SigW-1:0] m_reg;
    logic [11:0] e_reg;
    logic [5:0] lz_reg;
    logic [63:0] res_reg;
    logic inv_reg;
    logic inx_reg;
    logic start;
    dpsqrt_pkg::root_ctl_t rstat;
    logic [dpsqrt_pkg::SigW-1:0] root;
    logic rem_nz;
    logic rem_gt;

    logic [10:0] ebits;
    logic [51:0] frac;
    logic [5:0] lz;
    logic [dpsqrt_pkg::SigW:0] radicand;
    logic [11:0] e_odd;
    logic up;
    logic [dpsqrt_pkg::SigW:0] qr;
    logic [11:0] ehalf;
    logic [11:0] efinal;

    assign ebits = x_reg[62:52];
    assign frac = x_reg[51:0];

    // Leading zero count of the fraction for subnormal operands.
    always_comb
    begin
        lz = 6'd51;
        for (int i = 0; i < 52; i++)
        begin
            if (frac[i])
            begin
                lz = 6'(51 - i);
            end
        end
    end

    // Odd exponent doubles the significand.
    always_comb
    begin
        e_odd = e_reg;
        radicand = {1'b0, m_reg};
        if (e_reg[0])
        begin
            radicand = {m_reg, 1'b0};
            e_odd = e_reg - 12'd1;
        end
    end

    assign start = (state_reg == ST_NORM) && !x_reg[63] && (ebits != 11'h7FF)
        && (x_reg[62:0] != '0) && (lz_reg == 6'd63);

    dpsqrt_root u_root (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .radicand(radicand),
        .status(rstat),
        .root(root),
        .rem_nonzero(rem_nz),
        .rem_gt_root(rem_gt)
    );

    // Rounding and exponent.
    always_comb
    begin
        case (mode_reg)
            dpsqrt_pkg::RmNearest: up = rem_nz && rem_gt;
            dpsqrt_pkg::RmUp:      up = rem_nz;
            default:               up = 1'b0;
        endcase
        qr = {1'b0, root} + {{dpsqrt_pkg::SigW{1'b0}}, up};
        ehalf = {e_odd[11], e_odd[11:1]};
        efinal = ehalf + 12'(dpsqrt_pkg::ExpBias) + {11'd0, qr[dpsqrt_pkg::SigW]};
    end

    // Rounding mode register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= dpsqrt_pkg::RmNearest;
        end
        else if (cfg_we)
        begin
            mode_reg <= cfg_wdata;
        end
    end

    // Sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE: if (s_axis_tvalid) state_reg <= ST_NORM;
                ST_NORM:
                begin
                    if (start) state_reg <= ST_ROOT;
                    else if (lz_reg != 6'd62) state_reg <= ST_OUT;
                end
                ST_ROOT: if (rstat.done) state_reg <= ST_RND;
                ST_RND: state_reg <= ST_OUT;
                ST_OUT: if (m_axis_tready) state_reg <= ST_IDLE;
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Datapath. lz_reg 62 marks a pending normalize step, 63 ready to start,
    // 0 a special operand whose result is already set.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                x_reg <= s_axis_tdata;
                lz_reg <= 6'd62;
            end
            ST_NORM:
            begin
                if (lz_reg == 6'd62)
                begin
                    inv_reg <= 1'b0;
                    inx_reg <= 1'b0;
                    res_reg <= x_reg;
                    if (ebits == 11'h7FF)
                    begin
                        lz_reg <= 6'd0;
                        if (frac != '0)
                        begin
                            inv_reg <= !frac[51];
                            res_reg <= x_reg | dpsqrt_pkg::QuietBit;
                        end
                        else if (x_reg[63])
                        begin
                            inv_reg <= 1'b1;
                            res_reg <= dpsqrt_pkg::DefaultNan;
                        end
                    end
                    else if (x_reg[62:0] == '0)
                    begin
                        lz_reg <= 6'd0;
                        res_reg <= x_reg;
                    end
                    else if (x_reg[63])
                    begin
                        lz_reg <= 6'd0;
                        inv_reg <= 1'b1;
                        res_reg <= dpsqrt_pkg::DefaultNan;
                    end
                    else
                    begin
                        lz_reg <= 6'd63;
                        if (ebits == '0)
                        begin
                            m_reg <= {frac, 1'b0} << lz;
                            e_reg <= 12'(51) - {6'd0, lz} - 12'd1074;
                        end
                        else
                        begin
                            m_reg <= {1'b1, frac};
                            e_reg <= {1'b0, ebits} - 12'(dpsqrt_pkg::ExpBias);
                        end
                    end
                end
            end
            ST_RND:
            begin
                inx_reg <= rem_nz;
                res_reg <= {1'b0, efinal[10:0],
                    qr[dpsqrt_pkg::SigW] ? qr[dpsqrt_pkg::SigW-1:1] : qr[51:0]};
            end
            default:
            begin
            end
        endcase
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = (state_reg == ST_OUT);
    assign m_axis_tdata = res_reg;
    assign m_axis_tuser = {inx_reg, inv_reg};

`ifndef ASSERT_OFF
    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("both sides open");
    a_root_done: assert property (@(posedge clk) disable iff (!rst_n)
        rstat.done |-> state_reg == ST_ROOT)
        else $error("root done outside root state");
    a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");
`endif

endmodule

@@ hw/rtl/dpsqrt_root.sv @@
// Restoring integer square root, one result bit per cycle.
module dpsqrt_root (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    input  logic [dpsqrt_pkg::SigW:0]              radicand,
    output dpsqrt_pkg::root_ctl_t                  status,
    output logic [dpsqrt_pkg::SigW-1:0]            root,
    output logic                                   rem_nonzero,
    output logic                                   rem_gt_root
);

    logic [dpsqrt_pkg::SigW:0] rad_reg;
    logic [dpsqrt_pkg::RemW-1:0] rem_reg;
    logic [dpsqrt_pkg::SigW-1:0] q_reg;
    logic [5:0] cnt_reg;
    logic busy_reg;
    logic done_reg;
    logic [dpsqrt_pkg::RemW-1:0] shifted;
    logic [dpsqrt_pkg::RemW-1:0] trial;
    logic [dpsqrt_pkg::RemW:0] diff;

    // Bring down the next radicand pair and try the subtraction.
    always_comb
    begin
        shifted = {rem_reg[dpsqrt_pkg::RemW-3:0], rad_reg[dpsqrt_pkg::SigW:dpsqrt_pkg::SigW-1]};
        trial = {1'b0, q_reg, 2'b01};
        diff = {1'b0, shifted} - {1'b0, trial};
    end

    // Iteration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'(dpsqrt_pkg::IterN - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: remainder, partial root and radicand shift line.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg <= radicand;
            rem_reg <= '0;
            q_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg <= {rad_reg[dpsqrt_pkg::SigW-2:0], 2'b00};
            if (!diff[dpsqrt_pkg::RemW])
            begin
                rem_reg <= diff[dpsqrt_pkg::RemW-1:0];
                q_reg <= {q_reg[dpsqrt_pkg::SigW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted;
                q_reg <= {q_reg[dpsqrt_pkg::SigW-2:0], 1'b0};
            end
        end
    end

    assign status.start = start;
    assign status.done = done_reg;
    assign root = q_reg;
    assign rem_nonzero = (rem_reg != '0);
    assign rem_gt_root = (rem_reg > {3'b000, q_reg});

`ifndef ASSERT_OFF
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("root done while busy");
    a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("root started while busy");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("done held");
`endif

endmodule
